### sv/kcl_pkg.sv
// Package for the keypad code lock: result status codes, the try reset value and the key and position widths.
// No dependencies.
package kcl_pkg;

  // status code of one result item
  typedef enum logic [3:0] {
    ST_DIGIT        = 4'd0,
    ST_CODE_SET     = 4'd1,
    ST_BACKUP_SET   = 4'd2,
    ST_OPENED       = 4'd3,
    ST_WRONG_RETRY  = 4'd4,
    ST_WRONG_BACKUP = 4'd5,
    ST_BACKUP_OK    = 4'd6,
    ST_LOCKOUT      = 4'd7,
    ST_IGNORED      = 4'd8
  } status_e;

  // reset value of the max tries register
  localparam logic [3:0] MaxTriesReset = 4'd2;

  // width of a key code and of the digit position
  localparam int unsigned KeyW = 8;
  localparam int unsigned PosW = 3;

endpackage

### sv/keypad_code_lock_fsm.sv
// Keypad code lock: enrollment, code entry, backup entry and lockout control.
// Main and backup codes live in one synchronous code memory. Depends on kcl_pkg.
//
// Result: the result item is registered and is valid in the cycle after the key item is taken.
// Throughput: one key item per cycle while results are taken; the next stored digit is fetched from the
// code memory while the current item is taken, so it is ready for the next one.
// Reset: asynchronous, back to main-code enrollment with the try limit and tries
// both at 2; code memory contents are not cleared and are rewritten before any compare.
module keypad_code_lock_fsm #(
  parameter int unsigned CODE_LEN   = 4,
  parameter int unsigned BACKUP_LEN = 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [3:0]                cfg_wdata_i,
  // key items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kcl_pkg::KeyW-1:0]  key_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                status_o,
  output logic [2:0]                phase_o,
  output logic [kcl_pkg::PosW-1:0]  digit_position_o,
  output logic [3:0]                tries_left_o,
  output logic                      lock_open_o,
  output logic                      alarm_on_o
);

  localparam int unsigned Depth = CODE_LEN + BACKUP_LEN;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [kcl_pkg::PosW:0] CodeLenC   = (kcl_pkg::PosW + 1)'(CODE_LEN);
  localparam logic [kcl_pkg::PosW:0] BackupLenC = (kcl_pkg::PosW + 1)'(BACKUP_LEN);

  typedef enum logic [2:0] {
    PH_ENROLL_CODE   = 3'd0,
    PH_ENROLL_BACKUP = 3'd1,
    PH_ENTER_CODE    = 3'd2,
    PH_ENTER_BACKUP  = 3'd3,
    PH_OPENED        = 3'd4,
    PH_LOCKOUT       = 3'd5
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic [kcl_pkg::PosW-1:0]   pos_q, pos_d;
  logic [3:0]                 tries_q, tries_d;
  logic                       alarm_q, alarm_d;
  logic                       mis_q, mis_d;
  logic [3:0]                 try_limit_q;
  kcl_pkg::status_e           status_q, status_d;
  logic                       out_valid_q;

  // code memory: main code at 0.., backup code after it
  logic [kcl_pkg::KeyW-1:0]   mem_q [Depth];
  logic [kcl_pkg::KeyW-1:0]   rdata_q;
  logic                       mem_we, mem_re;
  logic [AddrW-1:0]           waddr, raddr;

  logic                       in_fire;
  logic [kcl_pkg::PosW:0]     pos_inc;
  logic                       key_diff, mis_new;

  // handshake: the result register frees up when taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign key_diff = key_i != rdata_q;
  assign mis_new  = (pos_q == '0) ? key_diff : (mis_q | key_diff);

  // next state of one key item
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    tries_d  = tries_q;
    alarm_d  = alarm_q;
    mis_d    = mis_q;
    status_d = kcl_pkg::ST_IGNORED;
    mem_we   = 1'b0;
    waddr    = AddrW'(pos_q);
    case (phase_q)
      PH_ENROLL_CODE: begin
        status_d = kcl_pkg::ST_DIGIT;
        mem_we   = 1'b1;
        if (pos_inc >= CodeLenC) begin
          pos_d    = '0;
          status_d = kcl_pkg::ST_CODE_SET;
          phase_d  = PH_ENROLL_BACKUP;
        end else begin
          pos_d = pos_inc[kcl_pkg::PosW-1:0];
        end
      end
      PH_ENROLL_BACKUP: begin
        status_d = kcl_pkg::ST_DIGIT;
        mem_we   = 1'b1;
        waddr    = AddrW'(int'(pos_q) + CODE_LEN);
        if (pos_inc >= BackupLenC) begin
          pos_d    = '0;
          status_d = kcl_pkg::ST_BACKUP_SET;
          phase_d  = PH_ENTER_CODE;
          tries_d  = try_limit_q;
        end else begin
          pos_d = pos_inc[kcl_pkg::PosW-1:0];
        end
      end
      PH_ENTER_CODE: begin
        status_d = kcl_pkg::ST_DIGIT;
        mis_d    = mis_new;
        if (pos_inc >= CodeLenC) begin
          pos_d = '0;
          if (!mis_new) begin
            status_d = kcl_pkg::ST_OPENED;
            phase_d  = PH_OPENED;
          end else if (tries_q > 4'd1) begin
            status_d = kcl_pkg::ST_WRONG_RETRY;
            tries_d  = tries_q - 4'd1;
          end else begin
            status_d = kcl_pkg::ST_WRONG_BACKUP;
            tries_d  = '0;
            alarm_d  = 1'b1;
            phase_d  = PH_ENTER_BACKUP;
          end
        end else begin
          pos_d = pos_inc[kcl_pkg::PosW-1:0];
        end
      end
      PH_ENTER_BACKUP: begin
        status_d = kcl_pkg::ST_DIGIT;
        mis_d    = mis_new;
        if (pos_inc >= BackupLenC) begin
          pos_d = '0;
          if (!mis_new) begin
            // codes count as erased: enrollment rewrites every entry before a compare
            status_d = kcl_pkg::ST_BACKUP_OK;
            alarm_d  = 1'b0;
            tries_d  = try_limit_q;
            phase_d  = PH_ENROLL_CODE;
          end else begin
            status_d = kcl_pkg::ST_LOCKOUT;
            phase_d  = PH_LOCKOUT;
          end
        end else begin
          pos_d = pos_inc[kcl_pkg::PosW-1:0];
        end
      end
      default: begin
        status_d = kcl_pkg::ST_IGNORED;
      end
    endcase
  end

  // prefetch the stored digit that the next key is compared against
  always_comb begin
    mem_re = 1'b0;
    raddr  = AddrW'(pos_d);
    case (phase_d)
      PH_ENTER_CODE: begin
        mem_re = 1'b1;
      end
      PH_ENTER_BACKUP: begin
        mem_re = 1'b1;
        raddr  = AddrW'(int'(pos_d) + CODE_LEN);
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // code memory; writes only happen in enroll phases and reads only feed entry
  // phases, so a read never targets the entry written in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      mem_q[waddr] <= key_i;
    end
    if (in_fire && mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      try_limit_q <= kcl_pkg::MaxTriesReset;
    end else if (cfg_we_i) begin
      try_limit_q <= cfg_wdata_i;
    end
  end

  // control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ENROLL_CODE;
      pos_q       <= '0;
      tries_q     <= kcl_pkg::MaxTriesReset;
      alarm_q     <= 1'b0;
      mis_q       <= 1'b0;
      status_q    <= kcl_pkg::ST_IGNORED;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        tries_q     <= tries_d;
        alarm_q     <= alarm_d;
        mis_q       <= mis_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // state only moves with an accepted item, so it equals the held result
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign phase_o          = phase_q;
  assign digit_position_o = pos_q;
  assign tries_left_o     = tries_q;
  assign lock_open_o      = (phase_q == PH_OPENED);
  assign alarm_on_o       = alarm_q;

  // an open lock never has the alarm running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_open_o |-> !alarm_on_o)
    else $error("alarm active while lock is open");

  // only reset leaves the opened and lockout phases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OPENED || phase_q == PH_LOCKOUT) |=> $stable(phase_q))
    else $error("left a terminal phase without reset");

  // the alarm is held exactly in backup entry and lockout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alarm_q |-> (phase_q == PH_ENTER_BACKUP || phase_q == PH_LOCKOUT))
    else $error("alarm set outside backup entry or lockout");

  // a held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(status_q) && $stable(phase_q)))
    else $error("pending result changed before it was taken");

endmodule

### bench/testbench.sv
// Testbench for keypad_code_lock_fsm: random enroll / entry / backup rounds with a
// cycle-free lock predictor, random idling on both item channels and a scoreboard.
// Depends on kcl_pkg and keypad_code_lock_fsm.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeLen    = 4;
  localparam int unsigned BackupLen  = 3;
  localparam int unsigned HoldCycles = 40;
  localparam int unsigned KeyTarget  = 1850;

  // phase codes as they appear on phase_o
  typedef enum logic [2:0] {
    PH_ENROLL_CODE   = 3'd0,
    PH_ENROLL_BACKUP = 3'd1,
    PH_ENTER_CODE    = 3'd2,
    PH_ENTER_BACKUP  = 3'd3,
    PH_OPENED        = 3'd4,
    PH_LOCKOUT       = 3'd5
  } lock_phase_e;

  // one result item
  typedef struct packed {
    kcl_pkg::status_e status;
    lock_phase_e      phase;
    logic [2:0]       digit_pos;
    logic [3:0]       tries_left;
    logic             lock_open;
    logic             alarm_on;
  } lock_result_t;

  // lock predictor and store of expected result items
  class lock_tracker;
    logic [3:0]                try_limit;
    lock_phase_e               phase;
    logic [CodeLen-1:0][7:0]   main_code;
    logic [BackupLen-1:0][7:0] backup_code;
    logic [CodeLen-1:0][7:0]   entry;
    logic [2:0]                pos;
    logic [3:0]                tries;
    logic                      alarm;
    lock_result_t              pending_results[$];
    int unsigned               mismatches;

    function new();
      try_limit   = kcl_pkg::MaxTriesReset;
      phase       = PH_ENROLL_CODE;
      main_code   = '0;
      backup_code = '0;
      entry       = '0;
      pos         = '0;
      tries       = kcl_pkg::MaxTriesReset;
      alarm       = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_try_limit(logic [3:0] value);
      try_limit = value;
    endfunction

    function lock_phase_e phase_now();
      return phase;
    endfunction

    function logic [3:0] tries_now();
      return tries;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // step the key position; 1 when the entry of len keys is complete
    function bit advance(int unsigned len);
      pos = pos + 3'd1;
      if (pos >= len) begin
        pos = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // predict the result item of one accepted key item
    function void take_key(logic [7:0] key);
      lock_result_t     r;
      kcl_pkg::status_e st;
      st = kcl_pkg::ST_IGNORED;
      case (phase)
        PH_ENROLL_CODE: begin
          st = kcl_pkg::ST_DIGIT;
          main_code[pos] = key;
          if (advance(CodeLen)) begin
            st    = kcl_pkg::ST_CODE_SET;
            phase = PH_ENROLL_BACKUP;
          end
        end
        PH_ENROLL_BACKUP: begin
          st = kcl_pkg::ST_DIGIT;
          backup_code[pos] = key;
          if (advance(BackupLen)) begin
            st    = kcl_pkg::ST_BACKUP_SET;
            phase = PH_ENTER_CODE;
            tries = try_limit;
          end
        end
        PH_ENTER_CODE: begin
          st = kcl_pkg::ST_DIGIT;
          entry[pos] = key;
          if (advance(CodeLen)) begin
            if (entry == main_code) begin
              st    = kcl_pkg::ST_OPENED;
              phase = PH_OPENED;
            end else if (tries > 4'd1) begin
              st    = kcl_pkg::ST_WRONG_RETRY;
              tries = tries - 4'd1;
            end else begin
              st    = kcl_pkg::ST_WRONG_BACKUP;
              tries = '0;
              alarm = 1'b1;
              phase = PH_ENTER_BACKUP;
            end
          end
        end
        PH_ENTER_BACKUP: begin
          st = kcl_pkg::ST_DIGIT;
          entry[pos] = key;
          if (advance(BackupLen)) begin
            if (entry[BackupLen-1:0] == backup_code) begin
              st          = kcl_pkg::ST_BACKUP_OK;
              main_code   = '1;
              backup_code = '1;
              alarm       = 1'b0;
              tries       = try_limit;
              phase       = PH_ENROLL_CODE;
            end else begin
              st    = kcl_pkg::ST_LOCKOUT;
              phase = PH_LOCKOUT;
            end
          end
        end
        default: st = kcl_pkg::ST_IGNORED;
      endcase
      r.status     = st;
      r.phase      = phase;
      r.digit_pos  = pos;
      r.tries_left = tries;
      r.lock_open  = (phase == PH_OPENED);
      r.alarm_on   = alarm;
      pending_results.push_back(r);
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(lock_result_t got);
      lock_result_t want;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("result item with none expected: status %0d phase %0d pos %0d tries %0d",
                   got.status, got.phase, got.digit_pos, got.tries_left);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("mismatch: expected status %0d phase %0d pos %0d tries %0d open %0b alarm %0b",
                   want.status, want.phase, want.digit_pos, want.tries_left,
                   want.lock_open, want.alarm_on);
          $display("          actual   status %0d phase %0d pos %0d tries %0d open %0b alarm %0b",
                   got.status, got.phase, got.digit_pos, got.tries_left,
                   got.lock_open, got.alarm_on);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] key_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [3:0] status_o;
  logic [2:0] phase_o;
  logic [2:0] digit_position_o;
  logic [3:0] tries_left_o;
  logic       lock_open_o;
  logic       alarm_on_o;

  lock_tracker tracker = new();

  logic [CodeLen-1:0][7:0]   enrolled_code;
  logic [BackupLen-1:0][7:0] enrolled_backup;
  int unsigned keys_sent    = 0;
  int unsigned calm_left[2] = '{0, 0};
  bit          hold_request = 1'b0;
  bit          tail_quiet   = 1'b0;

  keypad_code_lock_fsm #(
    .CODE_LEN  (CodeLen),
    .BACKUP_LEN(BackupLen)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .key_i           (key_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .phase_o         (phase_o),
    .digit_position_o(digit_position_o),
    .tries_left_o    (tries_left_o),
    .lock_open_o     (lock_open_o),
    .alarm_on_o      (alarm_on_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle burst length for one side (0 = no idling), with calm stretches
  function automatic int unsigned pick_idle(int side);
    if (calm_left[side] != 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm_left[side] = $urandom_range(20, 120);
      return 0;
    end
    if ($urandom_range(0, 5) == 0)
      return $urandom_range(1, 13);
    return 0;
  endfunction

  // key values biased toward the extremes
  function automatic logic [7:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_try_limit();
    case ($urandom_range(0, 3))
      0:       return 4'd1;
      1:       return 4'd15;
      default: return 4'($urandom_range(1, 15));
    endcase
  endfunction

  // offer one key item; returns at the falling edge after it is taken
  task automatic send_key(input logic [7:0] k);
    int unsigned gap;
    gap = tail_quiet ? 0 : pick_idle(0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_i      <= k;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_key(k);
    keys_sent++;
    @(negedge clk_i);
  endtask

  // stop offering and wait until every expected item has come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_try_limit(input logic [3:0] value);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_try_limit(value);
  endtask

  task automatic send_code(input logic [CodeLen-1:0][7:0] code);
    for (int i = 0; i < CodeLen; i++) send_key(code[i]);
  endtask

  task automatic send_backup(input logic [BackupLen-1:0][7:0] code);
    for (int i = 0; i < BackupLen; i++) send_key(code[i]);
  endtask

  // fresh main and backup codes
  task automatic enroll_codes();
    for (int i = 0; i < CodeLen; i++) enrolled_code[i] = rand_key();
    for (int i = 0; i < BackupLen; i++) enrolled_backup[i] = rand_key();
    send_code(enrolled_code);
    send_backup(enrolled_backup);
  endtask

  // wrong main code entry: near miss in one digit or fully random
  task automatic send_wrong_code();
    logic [CodeLen-1:0][7:0] guess;
    int unsigned             slot;
    if ($urandom_range(0, 1) == 1) begin
      guess = enrolled_code;
      slot  = $urandom_range(0, CodeLen - 1);
      guess[slot] = guess[slot] ^ 8'($urandom_range(1, 255));
    end else begin
      for (int i = 0; i < CodeLen; i++) guess[i] = rand_key();
      if (guess == enrolled_code) guess[0] = ~guess[0];
    end
    send_code(guess);
  endtask

  // enroll, use up every try, recover with the backup code
  task automatic lock_round();
    enroll_codes();
    if ($urandom_range(0, 5) == 0) write_try_limit(pick_try_limit());
    if ($urandom_range(0, 19) == 0) hold_request = 1'b1;
    while (tracker.phase_now() == PH_ENTER_CODE) send_wrong_code();
    send_backup(enrolled_backup);
  endtask

  // end in opened or lockout, then keys that are ignored
  task automatic closing_round();
    logic [BackupLen-1:0][7:0] bad_backup;
    int unsigned               wrong_count;
    int unsigned               slot;
    enroll_codes();
    if ($urandom_range(0, 1) == 1) begin
      wrong_count = $urandom_range(0, int'(tracker.tries_now()) - 1);
      repeat (wrong_count) send_wrong_code();
      send_code(enrolled_code);
    end else begin
      while (tracker.phase_now() == PH_ENTER_CODE) send_wrong_code();
      bad_backup = enrolled_backup;
      slot = $urandom_range(0, BackupLen - 1);
      bad_backup[slot] = bad_backup[slot] ^ 8'($urandom_range(1, 255));
      send_backup(bad_backup);
    end
    repeat (10) send_key(rand_key());
  endtask

  // stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    key_i       = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extreme keys, near misses, last try, backup accepted (reset tries)
    send_key(8'h00); send_key(8'hff); send_key(8'h55); send_key(8'haa);
    send_key(8'hff); send_key(8'h00); send_key(8'h80);
    send_key(8'h00); send_key(8'hff); send_key(8'h55); send_key(8'hab);
    send_key(8'hff); send_key(8'hff); send_key(8'h55); send_key(8'haa);
    send_key(8'hff); send_key(8'h00); send_key(8'h80);

    // tries at both extremes, with a long receiver hold-off
    write_try_limit(4'd1);
    lock_round();
    write_try_limit(4'd15);
    hold_request = 1'b1;
    lock_round();

    while (keys_sent < KeyTarget) begin
      if ($urandom_range(0, 2) == 0) write_try_limit(pick_try_limit());
      lock_round();
    end

    tail_quiet = 1'b1;
    closing_round();
    wait_results_drained();
    repeat (5) @(negedge clk_i);

    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("[keypad_code_lock_fsm] OK");
    else
      $display("[keypad_code_lock_fsm] ERROR");
    $finish;
  end

  // result side ready, with idle bursts and long hold-offs
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = tail_quiet ? 0 : pick_idle(1);
      if (hold_request && !tail_quiet) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // result item monitor
  always @(posedge clk_i) begin : result_monitor
    lock_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status     = kcl_pkg::status_e'(status_o);
      got.phase      = lock_phase_e'(phase_o);
      got.digit_pos  = digit_position_o;
      got.tries_left = tries_left_o;
      got.lock_open  = lock_open_o;
      got.alarm_on   = alarm_on_o;
      tracker.check_result(got);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("[keypad_code_lock_fsm] ERROR");
    $finish;
  end

endmodule

### sim.f
sv/kcl_pkg.sv
sv/keypad_code_lock_fsm.sv
bench/testbench.sv
